// ===== rtl/cpun_pkg.sv =====
package cpun_pkg;

  localparam int CompW  = 24;
  localparam int CrossW = 48;
  localparam int SumW   = 96;
  localparam int RootW  = 48;
  localparam int RemW   = 51;
  localparam int QuoW   = 31;
  localparam int ThrW   = 63;

  typedef struct packed {
    logic signed [CompW-1:0] a_x;
    logic signed [CompW-1:0] a_y;
    logic signed [CompW-1:0] a_z;
    logic signed [CompW-1:0] b_x;
    logic signed [CompW-1:0] b_y;
    logic signed [CompW-1:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [47:0] normal_x;
    logic signed [47:0] normal_y;
    logic signed [47:0] normal_z;
    logic [47:0]        magnitude;
    logic               degenerate;
  } rsp_t;

  typedef struct packed {
    logic signed [CrossW-1:0] cx;
    logic signed [CrossW-1:0] cy;
    logic signed [CrossW-1:0] cz;
    logic                     degen;
  } cross_t;

  function automatic logic [CrossW-1:0] abs_c(input logic signed [CrossW-1:0] v);
    abs_c = v[CrossW-1] ? CrossW'(-v) : CrossW'(v);
  endfunction

endpackage

// ===== rtl/cpun_cross.sv =====
module cpun_cross import cpun_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  req_t   in_req,
  output logic   out_valid,
  output cross_t out_cross
);

  logic v1;
  logic signed [CrossW-1:0] p0, p1, p2, p3, p4, p5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= in_req.a_y * in_req.b_z;
      p1 <= in_req.a_z * in_req.b_y;
      p2 <= in_req.a_z * in_req.b_x;
      p3 <= in_req.a_x * in_req.b_z;
      p4 <= in_req.a_x * in_req.b_y;
      p5 <= in_req.a_y * in_req.b_x;
      out_cross.cx    <= p0 - p1;
      out_cross.cy    <= p2 - p3;
      out_cross.cz    <= p4 - p5;
      out_cross.degen <= 1'b0;
    end
  end

endmodule

// ===== rtl/cpun_sumsq.sv =====
module cpun_sumsq import cpun_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [ThrW-1:0] thr,
  input  logic            in_valid,
  input  cross_t          in_cross,
  output logic            out_valid,
  output cross_t          out_cross,
  output logic [SumW-1:0] out_sum
);

  localparam int HalfW = CrossW / 2;

  logic v1, v2;
  cross_t c1, c2;
  logic [CrossW-1:0] m [3];
  logic [CrossW-1:0] hh [3];
  logic [CrossW-1:0] hl [3];
  logic [CrossW-1:0] ll [3];
  logic [SumW-1:0]   sq [3];
  logic [SumW-1:0]   sum_next;

  assign m[0] = abs_c(in_cross.cx);
  assign m[1] = abs_c(in_cross.cy);
  assign m[2] = abs_c(in_cross.cz);
  assign sum_next = sq[0] + sq[1] + sq[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        hh[k] <= m[k][CrossW-1:HalfW] * m[k][CrossW-1:HalfW];
        hl[k] <= m[k][CrossW-1:HalfW] * m[k][HalfW-1:0];
        ll[k] <= m[k][HalfW-1:0] * m[k][HalfW-1:0];
        sq[k] <= {hh[k], {CrossW{1'b0}}}
               + {{(HalfW-1){1'b0}}, hl[k], {(HalfW+1){1'b0}}}
               + {{CrossW{1'b0}}, ll[k]};
      end
      c1 <= in_cross;
      c2 <= c1;
      out_sum         <= sum_next;
      out_cross.cx    <= c2.cx;
      out_cross.cy    <= c2.cy;
      out_cross.cz    <= c2.cz;
      out_cross.degen <= (sum_next[SumW-1:ThrW] == '0) && (sum_next[ThrW-1:0] < thr);
    end
  end

endmodule

// ===== rtl/cpun_isqrt.sv =====
module cpun_isqrt import cpun_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cross_t           in_cross,
  input  logic [SumW-1:0]  in_sum,
  output logic             out_valid,
  output cross_t           out_cross,
  output logic [RootW-1:0] out_root
);

  localparam int Steps = SumW / 2;

  logic             v    [Steps+1];
  cross_t           cr   [Steps+1];
  logic [SumW-1:0]  s    [Steps+1];
  logic [RemW-1:0]  rem  [Steps+1];
  logic [RootW-1:0] root [Steps+1];

  assign v[0]    = in_valid;
  assign cr[0]   = in_cross;
  assign s[0]    = in_sum;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [RemW-1:0] rem_sh, trial;
    logic            ge;

    assign rem_sh = {rem[i][RemW-3:0], s[i][SumW-1:SumW-2]};
    assign trial  = {{(RemW-RootW-2){1'b0}}, root[i], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cr[i+1]   <= cr[i];
        s[i+1]    <= {s[i][SumW-3:0], 2'b00};
        rem[i+1]  <= ge ? rem_sh - trial : rem_sh;
        root[i+1] <= {root[i][RootW-2:0], ge};
      end
    end
  end

  assign out_valid = v[Steps];
  assign out_cross = cr[Steps];
  assign out_root  = root[Steps];

endmodule

// ===== rtl/cpun_div.sv =====
module cpun_div import cpun_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cross_t           in_cross,
  input  logic [RootW-1:0] in_root,
  output logic             out_valid,
  output cross_t           out_cross,
  output logic [RootW-1:0] out_root,
  output logic [QuoW-1:0]  out_q [3]
);

  logic             v   [QuoW+1];
  cross_t           cr  [QuoW+1];
  logic [RootW-1:0] len [QuoW+1];
  logic [RootW-1:0] rem [QuoW+1][3];
  logic [QuoW-1:0]  q   [QuoW+1][3];

  assign v[0]      = in_valid;
  assign cr[0]     = in_cross;
  assign len[0]    = in_root;
  assign rem[0][0] = abs_c(in_cross.cx);
  assign rem[0][1] = abs_c(in_cross.cy);
  assign rem[0][2] = abs_c(in_cross.cz);
  assign q[0][0]   = '0;
  assign q[0][1]   = '0;
  assign q[0][2]   = '0;

  for (genvar j = 0; j < QuoW; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [RootW:0] r;
      logic           ge;

      if (j == 0) begin : g_first
        assign r = {1'b0, rem[j][k]};
      end else begin : g_next
        assign r = {rem[j][k], 1'b0};
      end
      assign ge = r >= {1'b0, len[j]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1][k] <= ge ? RootW'(r - {1'b0, len[j]}) : RootW'(r);
          q[j+1][k]   <= {q[j][k][QuoW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cr[j+1]  <= cr[j];
        len[j+1] <= len[j];
      end
    end
  end

  assign out_valid = v[QuoW];
  assign out_cross = cr[QuoW];
  assign out_root  = len[QuoW];
  assign out_q[0]  = q[QuoW][0];
  assign out_q[1]  = q[QuoW][1];
  assign out_q[2]  = q[QuoW][2];

endmodule

// ===== rtl/cross_product_unit_normal.sv =====
// Cross product unit normal. Each request (two signed Q12.12 vectors) yields
// one response: the Q24.24 cross product length (floor of the square root of
// the Q48.48 sum of squares) and the truncated Q1.30 unit normal, or, when the
// sum of squares is below zero_threshold (reset 1), zero length, the raw cross
// components and the degenerate flag. The pipeline takes one request per cycle
// while not stalled and runs through, in order, the cross products, the sum of
// squares and threshold test, the square root (one root bit per stage), the
// three lane quotient (one quotient bit per stage) and an output register.
// out_stall with out_valid high freezes the whole pipeline; in_stall follows it.
module cross_product_unit_normal import cpun_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            zero_threshold_we,
  input  logic [ThrW-1:0] zero_threshold_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  req_t            in_req,
  output logic            out_valid,
  input  logic            out_stall,
  output rsp_t            out_rsp
);

  logic             en;
  logic [ThrW-1:0]  thr;
  logic             x_valid, s_valid, r_valid, d_valid;
  cross_t           x_cross, s_cross, r_cross, d_cross;
  logic [SumW-1:0]  s_sum;
  logic [RootW-1:0] r_root, d_root;
  logic [QuoW-1:0]  d_q [3];
  logic [47:0]      nrm [3];
  logic [CrossW-1:0] craw [3];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ThrW'(1);
    end else if (zero_threshold_we) begin
      thr <= zero_threshold_wdata;
    end
  end

  cpun_cross u_cross (
    .clk, .rst, .en,
    .in_valid, .in_req,
    .out_valid(x_valid), .out_cross(x_cross)
  );

  cpun_sumsq u_sumsq (
    .clk, .rst, .en, .thr,
    .in_valid(x_valid), .in_cross(x_cross),
    .out_valid(s_valid), .out_cross(s_cross), .out_sum(s_sum)
  );

  cpun_isqrt u_isqrt (
    .clk, .rst, .en,
    .in_valid(s_valid), .in_cross(s_cross), .in_sum(s_sum),
    .out_valid(r_valid), .out_cross(r_cross), .out_root(r_root)
  );

  cpun_div u_div (
    .clk, .rst, .en,
    .in_valid(r_valid), .in_cross(r_cross), .in_root(r_root),
    .out_valid(d_valid), .out_cross(d_cross), .out_root(d_root), .out_q(d_q)
  );

  assign craw[0] = d_cross.cx;
  assign craw[1] = d_cross.cy;
  assign craw[2] = d_cross.cz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (d_cross.degen) begin
        nrm[k] = 48'(craw[k]);
      end else if (d_root == '0) begin
        nrm[k] = '0;
      end else if (craw[k][CrossW-1]) begin
        nrm[k] = 48'(-{{(48-QuoW){1'b0}}, d_q[k]});
      end else begin
        nrm[k] = {{(48-QuoW){1'b0}}, d_q[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rsp.normal_x   <= nrm[0];
      out_rsp.normal_y   <= nrm[1];
      out_rsp.normal_z   <= nrm[2];
      out_rsp.magnitude  <= d_cross.degen ? '0 : 48'(d_root);
      out_rsp.degenerate <= d_cross.degen;
    end
  end

endmodule

// ===== rtl/cpun_checker.sv =====
module cpun_checker import cpun_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rsp_t out_rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled response changed");

  a_degen_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.degenerate |-> out_rsp.magnitude == '0)
    else $error("degenerate response with nonzero length");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.degenerate && out_rsp.magnitude == '0 |->
      out_rsp.normal_x == '0 && out_rsp.normal_y == '0 && out_rsp.normal_z == '0)
    else $error("zero length with nonzero normal");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind cross_product_unit_normal cpun_checker u_cpun_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .out_rsp
);

// ===== test/tb_cross_product_unit_normal.sv =====
`timescale 1ns / 1ps

module tb_cross_product_unit_normal;
  import cpun_pkg::*;

  class normal_board;
    rsp_t pending[$];
    logic [ThrW-1:0] threshold;
    int mismatches;

    function void reset_threshold();
      threshold = 1;
    endfunction

    function void note_request(req_t r);
      logic signed [47:0] c [3];
      logic [47:0] m [3];
      logic [96:0] s;
      logic [63:0] len;
      logic [127:0] num;
      logic [63:0] q;
      rsp_t e;
      c[0] = 48'(r.a_y) * 48'(r.b_z) - 48'(r.a_z) * 48'(r.b_y);
      c[1] = 48'(r.a_z) * 48'(r.b_x) - 48'(r.a_x) * 48'(r.b_z);
      c[2] = 48'(r.a_x) * 48'(r.b_y) - 48'(r.a_y) * 48'(r.b_x);
      s = 0;
      for (int k = 0; k < 3; k++) begin
        m[k] = c[k][47] ? 48'(-c[k]) : c[k];
        s += 97'(m[k]) * 97'(m[k]);
      end
      if (s < 97'(threshold)) begin
        e.normal_x = c[0];
        e.normal_y = c[1];
        e.normal_z = c[2];
        e.magnitude = 0;
        e.degenerate = 1;
      end else begin
        len = 0;
        for (int i = 63; i >= 0; i--) begin
          logic [63:0] cand;
          cand = len | (64'd1 << i);
          if (128'(cand) * 128'(cand) <= 128'(s)) len = cand;
        end
        for (int k = 0; k < 3; k++) begin
          num = 128'(m[k]) << 30;
          q = (len != 0) ? 64'(num / 128'(len)) : 64'd0;
          if (c[k][47]) q = -q;
          if (k == 0) e.normal_x = q[47:0];
          else if (k == 1) e.normal_y = q[47:0];
          else e.normal_z = q[47:0];
        end
        e.magnitude = (len > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : len[47:0];
        e.degenerate = 0;
      end
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.normal_x !== e.normal_x || got.normal_y !== e.normal_y ||
          got.normal_z !== e.normal_z || got.magnitude !== e.magnitude ||
          got.degenerate !== e.degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                   e.normal_x, e.normal_y, e.normal_z, e.magnitude, e.degenerate,
                   got.normal_x, got.normal_y, got.normal_z, got.magnitude,
                   got.degenerate);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic zero_threshold_we = 0;
  logic [ThrW-1:0] zero_threshold_wdata = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  req_t in_req = '0;
  rsp_t out_rsp;
  normal_board board;
  bit calm = 0;
  int sent = 0;

  cross_product_unit_normal uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_request(in_req);
    if (!rst && out_valid && !out_stall) board.check_response(out_rsp);
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 14);
        out_stall <= 1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  task automatic send(req_t r);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_req <= r;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] v);
    zero_threshold_wdata <= v;
    zero_threshold_we <= 1;
    @(negedge clk);
    zero_threshold_we <= 0;
    board.threshold = v;
  endtask

  function automatic logic signed [CompW-1:0] rand_comp(int mode);
    case (mode)
      0: return CompW'($urandom);
      1: return CompW'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return CompW'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int mode;
    mode = $urandom_range(0, 3);
    r.a_x = rand_comp(mode); r.a_y = rand_comp(mode); r.a_z = rand_comp(mode);
    r.b_x = rand_comp(mode); r.b_y = rand_comp(mode); r.b_z = rand_comp(mode);
    if ($urandom_range(0, 7) == 0) begin
      r.b_x = r.a_x; r.b_y = r.a_y; r.b_z = r.a_z;
    end
    return r;
  endfunction

  initial begin
    req_t r;
    logic [ThrW-1:0] thr [4];
    board = new();
    board.reset_threshold();
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    r = '0; send(r);
    r = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF};
    send(r);
    r = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000};
    send(r);
    r = '{24'sh800000, 0, 0, 0, 24'sh800000, 0}; send(r);
    r = '{24'sh7FFFFF, 0, 0, 0, 24'sh7FFFFF, 0}; send(r);
    r = '{1, 0, 0, 0, 1, 0}; send(r);
    r = '{1, 2, 3, 2, 4, 6}; send(r);
    r = '{-1, 0, 0, 0, 0, -1}; send(r);
    r = '{4096, 0, 0, 0, 4096, 0}; send(r);
    r = '{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 24'shAAAAAA, 24'sh555555, 24'shF0F0F0};
    send(r);
    drain();
    write_threshold(0);
    r = '0; send(r);
    r = '{1, 0, 0, 0, 1, 0}; send(r);
    drain();
    write_threshold({ThrW{1'b1}});
    r = '{24'sh7FFFFF, 0, 0, 0, 24'sh7FFFFF, 0}; send(r);
    r = '{24'sh800000, 24'sh800000, 0, 0, 24'sh800000, 24'sh800000}; send(r);
    r = '{3, -5, 7, -2, 9, 4}; send(r);
    drain();

    thr[0] = 1;
    thr[1] = 63'd1 << 40;
    thr[2] = 63'd1 << 70 >> 10;
    thr[3] = 0;
    for (int p = 0; p < 4; p++) begin
      drain();
      write_threshold(p == 2 ? ThrW'({$urandom, $urandom} >> 4) : thr[p]);
      for (int i = 0; i < 135; i++) begin
        if (p == 3 && i > 60) calm = 1;
        send(rand_req());
      end
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (board.mismatches == 0) $display("tb_cross_product_unit_normal OK");
    else $display("tb_cross_product_unit_normal NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_cross_product_unit_normal NOT OK");
    $finish;
  end
endmodule
